// File: rtl/dcfs_pkg.sv
// shared types, constants and helpers for the digit chain frame sequencer
// no dependencies; every other file refers to it by scoped names
package dcfs_pkg;

    // largest chain and digit counts the block honors
    localparam logic [3:0] MAX_CHIPS  = 4'd8;
    localparam logic [3:0] MAX_DIGITS = 4'd8;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // data bit that lights the decimal point
    localparam logic [7:0] DP_BIT    = 8'h80;
    // register address of a no-op word
    localparam logic [7:0] NOOP_ADDR = 8'h00;

    // configuration register indexes
    localparam logic CFG_DIGITS = 1'b0;
    localparam logic CFG_CHIPS  = 1'b1;

    // command codes
    localparam logic CMD_WRITE_DIGIT = 1'b0;
    localparam logic CMD_BROADCAST   = 1'b1;

    typedef struct packed {
        logic       command;
        logic [5:0] position;
        logic [7:0] value;
        logic       decimal_point;
        logic [3:0] reg_addr;
    } t_item;

    typedef struct packed {
        logic [15:0] spi_word;
        logic        latch_after;
        logic        last;
        logic        rejected;
    } t_result;

    // effective (clamped) configuration
    typedef struct packed {
        logic [3:0] digits;
        logic [3:0] chips;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_BCAST  = 2'd0,
        JOB_DIGIT  = 2'd1,
        JOB_REJECT = 2'd2
    } t_job_kind;

    // one classified item handed from front to back
    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] word;
        logic [3:0]  target_chip;
        logic [3:0]  chips;
    } t_job;

    // clamp a register value into 1..limit
    function automatic logic [3:0] clamp_count(input logic [3:0] v, input logic [3:0] limit);
        logic [3:0] r;
        r = v;
        if (r == 4'd0) begin
            r = 4'd1;
        end
        if (r > limit) begin
            r = limit;
        end
        return r;
    endfunction

endpackage

// File: rtl/dcfs_front.sv
// front end: accepts items, range checks, splits position into chip and digit
// depends on dcfs_pkg
module dcfs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dcfs_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    input  dcfs_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_q_wr,
    output dcfs_pkg::t_job  o_q_job,
    input  logic            i_q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate        r_state, n_state;
    logic [5:0]     r_rem, n_rem;
    logic [3:0]     r_chip, n_chip;
    dcfs_pkg::t_job r_job, n_job;
    logic [7:0]     limit;
    logic [7:0]     data;

    assign limit = 8'(i_cfg.digits) * 8'(i_cfg.chips);
    assign data  = i_item.decimal_point ? (i_item.value | dcfs_pkg::DP_BIT) : i_item.value;

    assign o_full  = (r_state != F_IDLE);
    assign o_q_wr  = (r_state == F_PUSH);
    assign o_q_job = r_job;

    // classify on transfer, then for a write-digit divide the position by repeated subtraction
    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_chip  = r_chip;
        n_job   = r_job;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_job.chips       = i_cfg.chips;
                    n_job.target_chip = 4'd0;
                    if (i_item.command == dcfs_pkg::CMD_BROADCAST) begin
                        n_job.kind = dcfs_pkg::JOB_BCAST;
                        n_job.word = {4'd0, i_item.reg_addr, i_item.value};
                        n_state    = F_PUSH;
                    end else if ({2'd0, i_item.position} >= limit) begin
                        n_job.kind = dcfs_pkg::JOB_REJECT;
                        n_job.word = 16'd0;
                        n_state    = F_PUSH;
                    end else begin
                        n_job.kind = dcfs_pkg::JOB_DIGIT;
                        n_job.word = {8'd0, data};
                        n_rem      = i_item.position;
                        n_chip     = 4'd0;
                        n_state    = F_DIV;
                    end
                end
            end
            F_DIV: begin
                if (r_rem >= {2'd0, i_cfg.digits}) begin
                    n_rem  = r_rem - {2'd0, i_cfg.digits};
                    n_chip = r_chip + 4'd1;
                end else begin
                    n_job.word[15:8]  = {4'd0, r_rem[3:0] + 4'd1};
                    n_job.target_chip = r_chip;
                    n_state           = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem  <= n_rem;
        r_chip <= n_chip;
        r_job  <= n_job;
    end

endmodule

// File: rtl/dcfs_queue.sv
// short job queue between front and back
// depends on dcfs_pkg
module dcfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dcfs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_rd,
    output dcfs_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int AW = (dcfs_pkg::QUEUE_DEPTH > 1) ? $clog2(dcfs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(dcfs_pkg::QUEUE_DEPTH + 1);

    dcfs_pkg::t_job r_mem [dcfs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_ok, rd_ok;

    assign o_full  = (r_count == CW'(dcfs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(dcfs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(dcfs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/dcfs_back.sv
// back end: expands one job into its serial words, one per cycle while the output register is free to take it
// depends on dcfs_pkg
module dcfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  dcfs_pkg::t_job    i_q_job,
    output logic              o_q_rd,
    output logic              o_empty,
    input  logic              i_pop,
    output dcfs_pkg::t_result o_result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BCAST  = 6'b000010,
        S_DIGIT  = 6'b000100,
        S_AHEAD  = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_REJECT = 6'b100000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [3:0]        r_cnt, n_cnt;
    dcfs_pkg::t_job    r_job, n_job;
    dcfs_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic              emit;
    logic              cnt_one;
    logic [15:0]       noop_word;

    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign emit      = !r_out_valid || i_pop;
    assign cnt_one   = (r_cnt == 4'd1);
    assign noop_word = {dcfs_pkg::NOOP_ADDR, 8'd0};

    // word sequencer feeding the output register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_job       = r_job;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_q_rd      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd = 1'b1;
                    n_job  = i_q_job;
                    n_cnt  = i_q_job.chips;
                    unique case (i_q_job.kind)
                        dcfs_pkg::JOB_BCAST:  n_state = S_BCAST;
                        dcfs_pkg::JOB_DIGIT:  n_state = S_DIGIT;
                        dcfs_pkg::JOB_REJECT: n_state = S_REJECT;
                        default:              n_state = S_REJECT;
                    endcase
                end
            end
            S_BCAST: begin
                if (emit) begin
                    n_out       = '{spi_word: r_job.word, latch_after: cnt_one,
                                    last: cnt_one, rejected: 1'b0};
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt - 4'd1;
                    if (cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIGIT: begin
                if (emit) begin
                    n_out       = '{spi_word: r_job.word,
                                    latch_after: (r_job.target_chip == 4'd0),
                                    last: 1'b0, rejected: 1'b0};
                    n_out_valid = 1'b1;
                    if (r_job.target_chip == 4'd0) begin
                        n_cnt   = r_job.chips;
                        n_state = S_FLUSH;
                    end else begin
                        n_cnt   = r_job.target_chip;
                        n_state = S_AHEAD;
                    end
                end
            end
            S_AHEAD: begin
                // no-ops that push the digit word past the chips ahead of it
                if (emit) begin
                    n_out       = '{spi_word: noop_word, latch_after: cnt_one,
                                    last: 1'b0, rejected: 1'b0};
                    n_out_valid = 1'b1;
                    if (cnt_one) begin
                        n_cnt   = r_job.chips;
                        n_state = S_FLUSH;
                    end else begin
                        n_cnt = r_cnt - 4'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (emit) begin
                    n_out       = '{spi_word: noop_word, latch_after: cnt_one,
                                    last: cnt_one, rejected: 1'b0};
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt - 4'd1;
                    if (cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REJECT: begin
                if (emit) begin
                    n_out       = '{spi_word: 16'd0, latch_after: 1'b0,
                                    last: 1'b1, rejected: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cnt <= n_cnt;
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

// File: rtl/digit_chain_frame_sequencer.sv
// top level of the digit chain frame sequencer: config registers and wiring
// depends on dcfs_pkg, dcfs_front, dcfs_queue, dcfs_back
//
// Turns display commands into 16-bit register words for a chain of LED digit
// driver chips. Items enter through a queue-style port: an item transfers on a
// clock edge with push high and full low. Words leave the same way: while
// empty is low the oldest word sits on o_result, and it transfers when pop is
// high. Two registers (digits per chip, chips in chain) are written through
// i_cfg_we / i_cfg_index / i_cfg_data, and the user must see that they are
// written only while the block is idle; the block itself does not enforce it.
// A write-digit item stays in the front while its position is divided by
// repeated subtraction; a broadcast or rejection skips the division. The back
// loads one job from the queue and then emits its words in order. An item
// yields 1 to 2 * chips words, and the front takes one item at a time. When
// pop stays low the output register holds its word, the back stops, and the
// two-entry job queue and then full push back on the sender. Reset empties
// queue and output and sets 8 digits per chip and 1 chip.
module digit_chain_frame_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [3:0]        i_cfg_data,
    input  logic              push,
    input  dcfs_pkg::t_item   i_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output dcfs_pkg::t_result o_result
);

    logic [3:0]        r_digits_per_chip;
    logic [3:0]        r_chips_in_chain;
    dcfs_pkg::t_cfg    cfg;
    logic              q_wr, q_full, q_rd, q_empty;
    dcfs_pkg::t_job    q_wr_job, q_rd_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits_per_chip <= 4'd8;
            r_chips_in_chain  <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dcfs_pkg::CFG_DIGITS: r_digits_per_chip <= i_cfg_data;
                dcfs_pkg::CFG_CHIPS:  r_chips_in_chain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, large values clamp
    assign cfg.digits = dcfs_pkg::clamp_count(r_digits_per_chip, dcfs_pkg::MAX_DIGITS);
    assign cfg.chips  = dcfs_pkg::clamp_count(r_chips_in_chain, dcfs_pkg::MAX_CHIPS);

    dcfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_wr   (q_wr),
        .o_q_job  (q_wr_job),
        .i_q_full (q_full)
    );

    dcfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (q_wr_job),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_job   (q_rd_job),
        .o_empty (q_empty)
    );

    dcfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_rd_job),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

// File: dv/tb_digit_chain_frame_sequencer.sv
// self-checking testbench for digit_chain_frame_sequencer
// depends on dcfs_pkg and the rtl top; predicts every register word in step with
// each accepted item and checks the words as they are popped
`timescale 1ns / 100ps

module tb_digit_chain_frame_sequencer;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE       = 20;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 8;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_index = dcfs_pkg::CFG_DIGITS;
    logic [3:0] i_cfg_data = 4'd0;
    logic    push        = 1'b0;
    dcfs_pkg::t_item   i_item = '0;
    logic    pop         = 1'b0;
    logic    full;
    logic    empty;
    dcfs_pkg::t_result o_result;

    // raw register copies, as written
    logic [3:0] reg_digits = 4'd8;
    logic [3:0] reg_chips  = 4'd1;

    // words still owed by the block, oldest first
    dcfs_pkg::t_result frame_words[$];

    // stimulus controls for the pop side and the sender
    logic quiet    = 1'b0;
    logic hold_pop = 1'b0;

    int errors        = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int rejects_seen  = 0;
    int broadcasts    = 0;
    int cycle_count   = 0;
    dcfs_pkg::t_result want;

    digit_chain_frame_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // zero counts as one, large counts saturate
    function automatic int usable_count(input logic [3:0] raw, input logic [3:0] limit);
        int n;
        n = int'(raw);
        if (n == 0) begin
            n = 1;
        end
        if (n > int'(limit)) begin
            n = int'(limit);
        end
        return n;
    endfunction

    // expected register words for one item, appended to frame_words
    function automatic void predict_frame(input dcfs_pkg::t_item it);
        logic [15:0] words[16];
        logic        latch[16];
        int nd;
        int nc;
        int chip;
        int digit;
        int n;
        int k;
        dcfs_pkg::t_result r;
        nd = usable_count(reg_digits, dcfs_pkg::MAX_DIGITS);
        nc = usable_count(reg_chips, dcfs_pkg::MAX_CHIPS);
        n = 0;
        if (it.command == dcfs_pkg::CMD_BROADCAST) begin
            for (k = 0; k < nc; k++) begin
                words[n] = {4'h0, it.reg_addr, it.value};
                latch[n] = (k == nc - 1);
                n++;
            end
        end else if (int'(it.position) >= nd * nc) begin
            r.spi_word    = 16'h0000;
            r.latch_after = 1'b0;
            r.last        = 1'b1;
            r.rejected    = 1'b1;
            frame_words.push_back(r);
            return;
        end else begin
            chip  = int'(it.position) / nd;
            digit = int'(it.position) % nd;
            words[n] = {8'(digit + 1),
                        it.value | (it.decimal_point ? dcfs_pkg::DP_BIT : 8'h00)};
            latch[n] = (chip == 0);
            n++;
            // push the digit word past the chips ahead of its target
            for (k = 0; k < chip; k++) begin
                words[n] = {dcfs_pkg::NOOP_ADDR, 8'h00};
                latch[n] = (k == chip - 1);
                n++;
            end
            // latch-closed flush of the whole chain
            for (k = 0; k < nc; k++) begin
                words[n] = {dcfs_pkg::NOOP_ADDR, 8'h00};
                latch[n] = (k == nc - 1);
                n++;
            end
        end
        for (k = 0; k < n; k++) begin
            r.spi_word    = words[k];
            r.latch_after = latch[k];
            r.last        = (k == n - 1);
            r.rejected    = 1'b0;
            frame_words.push_back(r);
        end
    endfunction

    function automatic dcfs_pkg::t_item make_item(input logic cmd, input logic [5:0] pos,
                                                  input logic [7:0] val, input logic dp,
                                                  input logic [3:0] addr);
        dcfs_pkg::t_item it;
        it.command       = cmd;
        it.position      = pos;
        it.value         = val;
        it.decimal_point = dp;
        it.reg_addr      = addr;
        return it;
    endfunction

    // random item, positions mostly inside the chain
    function automatic dcfs_pkg::t_item random_item();
        dcfs_pkg::t_item it;
        int span;
        span = usable_count(reg_digits, dcfs_pkg::MAX_DIGITS) *
               usable_count(reg_chips, dcfs_pkg::MAX_CHIPS);
        it = make_item(1'($urandom_range(1, 0)), 6'($urandom_range(63, 0)),
                       8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                       4'($urandom_range(15, 0)));
        if ($urandom_range(99, 0) < 85) begin
            it.position = 6'($urandom_range(span - 1, 0));
        end
        return it;
    endfunction

    // one item transfer, push left high for a following item
    task automatic send_item(input dcfs_pkg::t_item it);
        if (!quiet && $urandom_range(99, 0) < 15) begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_frame(it);
        items_sent++;
        if (it.command == dcfs_pkg::CMD_BROADCAST) begin
            broadcasts++;
        end
    endtask

    // stop sending and wait for every owed word
    task automatic drain_results();
        push <= 1'b0;
        while (frame_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, one write each, block idle
    task automatic write_regs(input logic [3:0] digits, input logic [3:0] chips);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= dcfs_pkg::CFG_DIGITS;
        i_cfg_data  <= digits;
        @(posedge i_clk);
        reg_digits = digits;
        i_cfg_index <= dcfs_pkg::CFG_CHIPS;
        i_cfg_data  <= chips;
        @(posedge i_clk);
        reg_chips = chips;
        i_cfg_we <= 1'b0;
    endtask

    // reset values: 8 digits, 1 chip; field extremes and ignored fields
    task automatic test_reset_defaults();
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd0, 8'h00, 1'b0, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd7, 8'hff, 1'b1, 4'hf));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd3, 8'h05, 1'b1, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd8, 8'h12, 1'b0, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd63, 8'hff, 1'b1, 4'hf));
        send_item(make_item(dcfs_pkg::CMD_BROADCAST, 6'd0, 8'hff, 1'b0, 4'hf));
        send_item(make_item(dcfs_pkg::CMD_BROADCAST, 6'd63, 8'h00, 1'b1, 4'h0));
    endtask

    // zero and oversized register values, longest frame, chain edges
    task automatic test_clamping();
        write_regs(4'd0, 4'd0);
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd0, 8'h7e, 1'b1, 4'h3));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd1, 8'h7e, 1'b0, 4'h3));
        write_regs(4'd15, 4'd15);
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd63, 8'h55, 1'b1, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd0, 8'haa, 1'b0, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_BROADCAST, 6'd9, 8'h07, 1'b0, 4'hb));
        write_regs(4'd1, 4'd8);
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd7, 8'h33, 1'b0, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd8, 8'h33, 1'b0, 4'h0));
        write_regs(4'd3, 4'd5);
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd14, 8'h01, 1'b1, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd15, 8'h01, 1'b0, 4'h0));
        send_item(make_item(dcfs_pkg::CMD_WRITE_DIGIT, 6'd4, 8'h80, 1'b0, 4'h9));
    endtask

    // hold pop low long enough for the job queue and full to push back
    task automatic test_backpressure();
        write_regs(4'd8, 4'd8);
        hold_pop <= 1'b1;
        fork
            begin
                repeat (12) send_item(random_item());
            end
            begin
                repeat (150) @(posedge i_clk);
                hold_pop <= 1'b0;
            end
        join
    endtask

    // random items over several register settings, one phase with no idling
    task automatic test_random();
        int ph;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_regs(4'd8, 4'd8);
                end
                1: begin
                    write_regs(4'd1, 4'd1);
                end
                2: begin
                    write_regs(4'd15, 4'd0);
                end
                default: begin
                    write_regs(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)));
                end
            endcase
            quiet <= (ph == 3);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        quiet <= 1'b0;
    endtask

    // receiver side: pop with random stalls
    always @(posedge i_clk) begin
        if (hold_pop) begin
            pop <= 1'b0;
        end else begin
            pop <= quiet || ($urandom_range(99, 0) >= 15);
        end
    end

    // check each popped word against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (frame_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, o_result);
            end else begin
                want = frame_words.pop_front();
                words_checked++;
                if (want.rejected) begin
                    rejects_seen++;
                end
                if (o_result.spi_word !== want.spi_word) begin
                    errors++;
                    $display("%0t: spi_word expected %h actual %h", $time,
                             want.spi_word, o_result.spi_word);
                end
                if (o_result.latch_after !== want.latch_after) begin
                    errors++;
                    $display("%0t: latch_after expected %b actual %b", $time,
                             want.latch_after, o_result.latch_after);
                end
                if (o_result.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, o_result.last);
                end
                if (o_result.rejected !== want.rejected) begin
                    errors++;
                    $display("%0t: rejected expected %b actual %b", $time,
                             want.rejected, o_result.rejected);
                end
            end
        end
    end

    // run time guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("digit_chain_frame_sequencer test failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_clamping();
        test_backpressure();
        test_random();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d items (%0d broadcasts) over %0d register settings,",
                 items_sent, broadcasts, PHASES + 6);
        $display("checked %0d words, %0d of them rejections, %0d errors",
                 words_checked, rejects_seen, errors);
        if (errors == 0 && frame_words.size() == 0) begin
            $display("digit_chain_frame_sequencer test passed");
        end else begin
            $display("digit_chain_frame_sequencer test failed");
        end
        $finish;
    end

endmodule
